### sv/assert_macros.svh
// shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every edge outside reset
`define DFE_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition must never be seen outside reset
`define DFE_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

### sv/dfe_pkg.sv
package dfe_pkg;

   localparam int MAX_FIELD_DEFAULT = 32;

   // count field covers the whole MAX_FIELD range (up to 127)
   localparam int CNT_W = 7;

   localparam logic [7:0] QUOTE_CHAR = 8'h22;
   localparam logic [7:0] NUL_CHAR   = 8'h00;

   localparam logic [7:0] DELIM_RESET = 8'd44;
   localparam logic [7:0] INDEX_RESET = 8'd0;
   localparam logic [5:0] CAP_RESET   = 6'd32;

   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_DELIMITER   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FIELD_INDEX = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DEST_CAP    = 2'd2;

   localparam logic [1:0] ST_COMPLETE  = 2'd0;
   localparam logic [1:0] ST_TRUNCATED = 2'd1;
   localparam logic [1:0] ST_NOT_FOUND = 2'd2;

   typedef struct packed {
      logic [7:0] char_code;
      logic       end_of_string;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       run_last;
      logic [1:0] status;
   } rsp_type;

   // one run to deliver: buffer bank, byte count, status
   typedef struct packed {
      logic             bank;
      logic [CNT_W-1:0] count;
      logic [1:0]       status;
   } desc_type;

   // back part hands a bank back to the scanner
   typedef struct packed {
      logic valid;
      logic bank;
   } rel_type;

endpackage

### sv/dfe_desc_fifo.sv
module dfe_desc_fifo import dfe_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  desc_type push_data,
   output logic     full,
   input  logic     pop,
   output desc_type pop_data,
   output logic     empty
);

   desc_type   slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign pop_data = slot_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### sv/dfe_front.sv
module dfe_front import dfe_pkg::*; #(
   parameter int MAX_FIELD = MAX_FIELD_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  req_type              req_data,
   input  logic                 csr_write_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]           csr_wdata,
   output logic                 buf_we,
   output logic                 buf_bank,
   output logic [((MAX_FIELD > 1) ? $clog2(MAX_FIELD) : 1)-1:0] buf_addr,
   output logic [7:0]           buf_wdata,
   output logic                 desc_push,
   output desc_type             desc_data,
   input  logic                 fifo_full,
   input  rel_type              rel
);

   localparam int AW   = (MAX_FIELD > 1) ? $clog2(MAX_FIELD) : 1;
   localparam int LW   = $clog2(MAX_FIELD + 2);
   localparam int CMPW = (LW > 6) ? LW : 6;

   logic [7:0]    delim_ff, index_ff;
   logic [5:0]    cap_ff;
   logic [7:0]    fields_done_ff, fields_done_in;
   logic [LW-1:0] len_ff, len_in;
   logic          swq_ff, swq_in;
   logic          pwq_ff, pwq_in;
   logic          answered_ff, answered_in;
   logic          bank_ff, bank_in;
   logic [1:0]    busy_ff, busy_in;

   logic [7:0]      c;
   logic            accept, is_end, is_quote, len_nz, two_plus;
   logic            ok_delim, ok_end, hit;
   logic [CMPW-1:0] cap_ext, len_ext, n_ext;
   logic            trunc;

   assign req_full  = busy_ff[bank_ff] || fifo_full;
   assign accept    = req_push && !req_full;
   assign c         = req_data.char_code;
   assign is_end    = req_data.end_of_string || (c == NUL_CHAR);
   assign is_quote  = (c == QUOTE_CHAR);
   assign len_nz    = (len_ff != '0);
   assign two_plus  = (len_ff >= LW'(2));
   // an empty field takes its quote flag from the delimiter itself
   assign ok_delim  = !(len_nz ? swq_ff : is_quote) || (two_plus && pwq_ff);
   assign ok_end    = !(len_nz && swq_ff) || (two_plus && pwq_ff);
   assign hit       = (fields_done_ff == index_ff);

   assign cap_ext = (CMPW'(cap_ff) > CMPW'(MAX_FIELD)) ? CMPW'(MAX_FIELD) : CMPW'(cap_ff);
   assign len_ext = CMPW'(len_ff);
   assign n_ext   = (len_ext < cap_ext) ? len_ext : cap_ext;
   assign trunc   = (len_ext > cap_ext);

   assign buf_bank  = bank_ff;
   assign buf_addr  = AW'(len_ff);
   assign buf_wdata = c;

   always_comb begin
      fields_done_in   = fields_done_ff;
      len_in           = len_ff;
      swq_in           = swq_ff;
      pwq_in           = pwq_ff;
      answered_in      = answered_ff;
      buf_we           = 1'b0;
      desc_push        = 1'b0;
      desc_data.bank   = bank_ff;
      desc_data.count  = CNT_W'(n_ext);
      desc_data.status = trunc ? ST_TRUNCATED : ST_COMPLETE;
      if (accept) begin
         if (is_end) begin
            if (!answered_ff) begin
               desc_push = 1'b1;
               if (!(fields_done_ff != 8'd0 && hit && ok_end)) begin
                  desc_data.count  = '0;
                  desc_data.status = ST_NOT_FOUND;
               end
            end
            fields_done_in = 8'd0;
            len_in         = '0;
            swq_in         = 1'b0;
            pwq_in         = 1'b0;
            answered_in    = 1'b0;
         end else if (!answered_ff) begin
            if (c == delim_ff && ok_delim) begin
               if (hit) begin
                  desc_push   = 1'b1;
                  answered_in = 1'b1;
               end else begin
                  fields_done_in = fields_done_ff + 8'd1;
                  len_in         = '0;
                  swq_in         = 1'b0;
                  pwq_in         = 1'b0;
               end
            end else begin
               if (!len_nz) begin
                  swq_in = is_quote;
               end
               if (len_ff < LW'(MAX_FIELD)) begin
                  buf_we = 1'b1;
               end
               if (len_ff <= LW'(MAX_FIELD)) begin
                  len_in = len_ff + LW'(1);
               end
               pwq_in = is_quote;
            end
         end
      end
      bank_in = bank_ff ^ desc_push;
      busy_in = busy_ff;
      if (rel.valid) begin
         busy_in[rel.bank] = 1'b0;
      end
      if (desc_push) begin
         busy_in[bank_ff] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delim_ff       <= DELIM_RESET;
         index_ff       <= INDEX_RESET;
         cap_ff         <= CAP_RESET;
         fields_done_ff <= 8'd0;
         len_ff         <= '0;
         swq_ff         <= 1'b0;
         pwq_ff         <= 1'b0;
         answered_ff    <= 1'b0;
         bank_ff        <= 1'b0;
         busy_ff        <= 2'b00;
      end else begin
         if (csr_write_en) begin
            unique case (csr_index)
               CSR_DELIMITER:   delim_ff <= csr_wdata;
               CSR_FIELD_INDEX: index_ff <= csr_wdata;
               CSR_DEST_CAP:    cap_ff   <= csr_wdata[5:0];
               default: ;
            endcase
         end
         fields_done_ff <= fields_done_in;
         len_ff         <= len_in;
         swq_ff         <= swq_in;
         pwq_ff         <= pwq_in;
         answered_ff    <= answered_in;
         bank_ff        <= bank_in;
         busy_ff        <= busy_in;
      end
   end

`include "assert_macros.svh"

   `DFE_NEVER(a_push_into_full, clock, reset, desc_push && fifo_full, "run queued while queue full")
   `DFE_NEVER(a_release_idle_bank, clock, reset, rel.valid && !busy_ff[rel.bank], "idle bank released")

endmodule

### sv/dfe_back.sv
module dfe_back import dfe_pkg::*; #(
   parameter int MAX_FIELD = MAX_FIELD_DEFAULT
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     fifo_empty,
   input  desc_type fifo_data,
   output logic     fifo_pop,
   input  logic     buf_we,
   input  logic     buf_bank,
   input  logic [((MAX_FIELD > 1) ? $clog2(MAX_FIELD) : 1)-1:0] buf_addr,
   input  logic [7:0] buf_wdata,
   output rel_type  rel,
   output logic     rsp_empty,
   input  logic     rsp_pop,
   output rsp_type  rsp_data
);

   localparam int AW = (MAX_FIELD > 1) ? $clog2(MAX_FIELD) : 1;
   localparam int CW = $clog2(MAX_FIELD + 1);

   logic [7:0] buf_mem [2][MAX_FIELD];

   logic          active_ff, active_in;
   logic          act_bank_ff;
   logic [CW-1:0] n_ff, cnt_ff;
   logic [1:0]    act_status_ff;

   logic       rd_valid_ff, rd_valid_in;
   logic [7:0] rd_byte_ff;
   logic       rd_bv_ff, rd_last_ff;
   logic [1:0] rd_status_ff;

   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff;

   logic issue, is_last, out_load, rd_free;

   assign fifo_pop = !active_ff && !fifo_empty;
   assign out_load = rd_valid_ff && (!out_valid_ff || rsp_pop);
   assign rd_free  = !rd_valid_ff || out_load;
   assign issue    = active_ff && rd_free;
   assign is_last  = (n_ff == '0) || (CW'(cnt_ff + 1'b1) == n_ff);

   // bank goes back as soon as its last byte has been read
   assign rel.valid = issue && is_last;
   assign rel.bank  = act_bank_ff;

   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_data_ff;

   always_comb begin
      active_in = active_ff;
      if (fifo_pop) begin
         active_in = 1'b1;
      end else if (issue && is_last) begin
         active_in = 1'b0;
      end
      rd_valid_in = issue ? 1'b1 : (out_load ? 1'b0 : rd_valid_ff);
      out_valid_in = out_load ? 1'b1 : ((rsp_pop && out_valid_ff) ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         rd_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         rd_valid_ff  <= rd_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fifo_pop) begin
         act_bank_ff   <= fifo_data.bank;
         n_ff          <= CW'(fifo_data.count);
         act_status_ff <= fifo_data.status;
         cnt_ff        <= '0;
      end else if (issue) begin
         cnt_ff <= CW'(cnt_ff + 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (buf_we) begin
         buf_mem[buf_bank][buf_addr] <= buf_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         rd_byte_ff   <= buf_mem[act_bank_ff][cnt_ff[AW-1:0]];
         rd_bv_ff     <= (n_ff != '0);
         rd_last_ff   <= is_last;
         rd_status_ff <= act_status_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_data_ff.out_byte   <= rd_bv_ff ? rd_byte_ff : 8'd0;
         out_data_ff.byte_valid <= rd_bv_ff;
         out_data_ff.run_last   <= rd_last_ff;
         out_data_ff.status     <= rd_status_ff;
      end
   end

`include "assert_macros.svh"

   `DFE_ASSERT(a_empty_word_last, clock, reset, out_valid_ff && !out_data_ff.byte_valid |-> out_data_ff.run_last, "empty word not last")
   `DFE_ASSERT(a_cnt_in_run, clock, reset, active_ff && n_ff != '0 |-> cnt_ff < n_ff, "read index past run")

endmodule

### sv/delimited_field_extractor.sv
// Delimited field extractor.
// Input queue side (req_): push a word with req_push while req_full is low; a
// word is one character, or an end-of-string mark (end_of_string, or a zero
// character). Field number field_index, split on delimiter, is picked out.
// Result queue side (rsp_): while rsp_empty is low, rsp_data holds the oldest
// result word; rsp_pop takes it. One run of words per string: the field bytes
// (at most dest_capacity), or one empty word, with run_last on the final one.
// Configuration: csr_write_en with csr_index and csr_wdata, only while idle.
// Characters are taken one per cycle while req_full is low. The word closing
// a field sends its run through the run queue, buffer read register and
// output register; a run then drains at one word per cycle while rsp_pop keeps
// up, limited by the single read port of the field buffer.
// The buffer has two banks; the scanner writes one while the other drains, so
// req_full rises only when both banks hold runs not yet read out.
// A stalled receiver stops the drain, and in turn input once both banks fill.
// Reset (synchronous) empties both queues and restores the registers to
// delimiter 44, field_index 0, dest_capacity 32.
module delimited_field_extractor import dfe_pkg::*; #(
   parameter int MAX_FIELD = MAX_FIELD_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  req_type              req_data,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output rsp_type              rsp_data,
   input  logic                 csr_write_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]           csr_wdata
);

   localparam int AW = (MAX_FIELD > 1) ? $clog2(MAX_FIELD) : 1;

   logic          buf_we, buf_bank;
   logic [AW-1:0] buf_addr;
   logic [7:0]    buf_wdata;
   logic          desc_push, fifo_full, fifo_pop, fifo_empty;
   desc_type      desc_in, desc_out;
   rel_type       rel;

   dfe_front #(.MAX_FIELD(MAX_FIELD)) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_push     (req_push),
      .req_full     (req_full),
      .req_data     (req_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .buf_we       (buf_we),
      .buf_bank     (buf_bank),
      .buf_addr     (buf_addr),
      .buf_wdata    (buf_wdata),
      .desc_push    (desc_push),
      .desc_data    (desc_in),
      .fifo_full    (fifo_full),
      .rel          (rel)
   );

   dfe_desc_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (desc_push),
      .push_data (desc_in),
      .full      (fifo_full),
      .pop       (fifo_pop),
      .pop_data  (desc_out),
      .empty     (fifo_empty)
   );

   dfe_back #(.MAX_FIELD(MAX_FIELD)) u_back (
      .clock      (clock),
      .reset      (reset),
      .fifo_empty (fifo_empty),
      .fifo_data  (desc_out),
      .fifo_pop   (fifo_pop),
      .buf_we     (buf_we),
      .buf_bank   (buf_bank),
      .buf_addr   (buf_addr),
      .buf_wdata  (buf_wdata),
      .rel        (rel),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_data   (rsp_data)
   );

endmodule
